@@ rtl/grid_dda_raycaster_defines.svh @@
// Assertion macros used by the top-level raycaster module.
`ifndef GRID_DDA_RAYCASTER_DEFINES_SVH
`define GRID_DDA_RAYCASTER_DEFINES_SVH

// Consequent holds in the same cycle.
`define GDR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("raycaster check failed");

// Consequent holds in the next cycle.
`define GDR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("raycaster check failed");

`endif

@@ rtl/gdr_pkg.sv @@
`timescale 1ns / 1ps
package gdr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 640;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int DEF_MAP_DIM       = 64;
    localparam int DEF_MAX_STEPS     = 128;

    localparam int ONE_Q16  = 65536;
    localparam int COL_W    = 10;
    localparam int CELL_W   = 6;
    localparam int POS_W    = 22;
    localparam int VEC_W    = 18;
    localparam int DIST_W   = 24;
    localparam int LH_W     = 16;
    localparam int DS_W     = 8;
    localparam int DE_W     = 9;
    localparam int SIDE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 22;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 88;

    localparam int CAM_W    = 28;
    localparam int PROD_W   = 46;
    localparam int RAY_W    = 31;
    localparam int DELTA_W  = 32;
    localparam int SUM_W    = 43;

    localparam int DIV_N_W   = 33;
    localparam int DIV_D_W   = 31;
    localparam int DIV_CNT_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [SIDE_W-1:0] SIDE_XNEG = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_YNEG = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_XPOS = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_YPOS = 2'd3;

    typedef enum logic [1:0] {
        DIV_DX  = 2'd0,
        DIV_DY  = 2'd1,
        DIV_LH  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     clr_we;
        logic     map_we;
        logic     ld_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     ld_div;
        logic     ray_mul;
        logic     ray_add;
        logic     side_mul;
        logic     step;
        logic     calc_dist;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic div_done;
        logic wall;
        logic limit;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/grid_dda_raycaster.sv @@
`timescale 1ns / 1ps
// Map write: the cell is written as the item is accepted; the next transaction is accepted the cycle after.
// Cast: from accept to m_axis_tvalid, two reciprocal divisions, setup states, a step
// state and a check state per DDA step (registered map read), one height division
// and the output load; a ray out of steps skips the height division.
// One cast in flight; the next is accepted the cycle after the result is loaded.
// Reset (sync, active low): config regs to defaults, then a pass that clears all
// MAP_DIM*MAP_DIM map cells (4096 by default) with s_axis_tready low.
`include "grid_dda_raycaster_defines.svh"
module grid_dda_raycaster
    import gdr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int MAP_DIM       = DEF_MAP_DIM,
    parameter int MAX_STEPS     = DEF_MAX_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // column[9:0], cell_x[15:10], cell_y[21:16], cell_wall[22], zero[23]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // opcode[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_column[9:0], side[11:10], hit_x[17:12], hit_y[23:18],
    // wall_distance[47:24], line_height[63:48], start_row[71:64],
    // end_row[80:72], zero[87:81]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // no_hit[0]
    output logic                 m_axis_tuser
);
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    gdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_s_tready (s_axis_tready)
    );

    gdr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAP_DIM       (MAP_DIM),
        .MAX_STEPS     (MAX_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

    `GDR_ASSERT_SAME(a_div_start_idle, w_cmd.div_start, !w_stat.div_busy)
    `GDR_ASSERT_SAME(a_ready_div_idle, s_axis_tready, !w_stat.div_busy)
    `GDR_ASSERT_NEXT(a_cast_blocks_input, w_cmd.ld_in, !s_axis_tready)
    `GDR_ASSERT_SAME(a_nohit_sat, m_axis_tvalid && m_axis_tuser, m_axis_tdata[47:24] == '1 && m_axis_tdata[63:48] == '0)
endmodule

@@ rtl/gdr_ram.sv @@
`timescale 1ns / 1ps
module gdr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/gdr_div.sv @@
`timescale 1ns / 1ps
module gdr_div
    import gdr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quo
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W:0]     w_trial;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_trial[DIV_D_W-1:0];
            r_quo <= {r_quo[DIV_N_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ rtl/gdr_datapath.sv @@
`timescale 1ns / 1ps
module gdr_datapath
    import gdr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int MAP_DIM       = DEF_MAP_DIM,
    parameter int MAX_STEPS     = DEF_MAX_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tuser
);
    localparam int DEPTH  = MAP_DIM * MAP_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int M_W    = $clog2(MAX_STEPS + MAP_DIM) + 2;
    localparam int LIN_W  = M_W + 10;
    localparam int N_W    = $clog2(MAX_STEPS + 1);
    localparam int HALF   = SCREEN_HEIGHT / 2;
    localparam logic [DIV_N_W-1:0] LH_NUM = DIV_N_W'(SCREEN_HEIGHT * ONE_Q16);
    // camera x = col * 2^17 / width - 2^16, by reciprocal multiply (exact for 10-bit columns)
    localparam logic [38:0] CAM_RECIP =
        39'(((64'd1 << 39) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    logic [POS_W-1:0]        r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [COL_W-1:0]        r_col;
    logic signed [CAM_W-1:0] r_camx;
    logic signed [PROD_W-1:0] r_prod_x, r_prod_y;
    logic signed [RAY_W-1:0] r_rx, r_ry;
    logic [DELTA_W-1:0]      r_dx, r_dy;
    logic [SUM_W-1:0]        r_sx, r_sy;
    logic signed [M_W-1:0]   r_mx, r_my;
    logic [N_W-1:0]          r_n;
    logic [SIDE_W-1:0]       r_side;
    logic                    r_hit;
    logic [DIST_W-1:0]       r_dist;
    logic [LH_W-1:0]         r_lh;
    logic [ADDR_W-1:0]       r_clr;
    logic                    r_m_tvalid;
    logic [M_TDATA_W-1:0]    r_m_tdata;
    logic                    r_m_tuser;

    logic [DIV_N_W-1:0]      w_num, w_quo;
    logic [DIV_D_W-1:0]      w_den;
    logic                    w_div_busy, w_div_done;
    logic [48:0]             w_cam_prod;
    logic [RAY_W-1:0]        w_ax, w_ay;
    logic [16:0]             w_fx, w_fy;
    logic [48:0]             w_px, w_py;
    logic                    w_xstep;
    logic signed [M_W-1:0]   w_nmx, w_nmy;
    logic signed [LIN_W-1:0] w_lin;
    logic                    w_oob;
    logic                    w_rd;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic                    w_wdata;
    logic [COL_W-1:0]        w_in_col;
    logic [CELL_W-1:0]       w_in_cx, w_in_cy;
    logic                    w_in_wall;
    logic [SUM_W-1:0]        w_perp;
    logic [16:0]             w_half_lh;
    logic [16:0]             w_de_sum;
    logic [DS_W-1:0]         w_ds;
    logic [DE_W-1:0]         w_de;

    assign w_in_col  = i_s_tdata[9:0];
    assign w_in_cx   = i_s_tdata[15:10];
    assign w_in_cy   = i_s_tdata[21:16];
    assign w_in_wall = i_s_tdata[22];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= POS_W'(98304);
            r_pos_y   <= POS_W'(98304);
            r_dir_x   <= VEC_W'(65536);
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= VEC_W'(43254);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POS_X:   r_pos_x   <= i_cfg_data;
                REG_POS_Y:   r_pos_y   <= i_cfg_data;
                REG_DIR_X:   r_dir_x   <= i_cfg_data[VEC_W-1:0];
                REG_DIR_Y:   r_dir_y   <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_X: r_plane_x <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_Y: r_plane_y <= i_cfg_data[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_DX: begin
                w_num = DIV_N_W'(64'h1_0000_0000);
                w_den = w_ax;
            end
            DIV_DY: begin
                w_num = DIV_N_W'(64'h1_0000_0000);
                w_den = w_ay;
            end
            DIV_LH: begin
                w_num = LH_NUM;
                w_den = DIV_D_W'(r_dist);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    gdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_cam_prod = 49'(w_in_col) * 49'(CAM_RECIP);

    assign w_ax = r_rx[RAY_W-1] ? RAY_W'(-r_rx) : RAY_W'(r_rx);
    assign w_ay = r_ry[RAY_W-1] ? RAY_W'(-r_ry) : RAY_W'(r_ry);
    assign w_fx = r_rx[RAY_W-1] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign w_fy = r_ry[RAY_W-1] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};
    assign w_px = 49'(w_fx) * 49'(r_dx);
    assign w_py = 49'(w_fy) * 49'(r_dy);

    assign w_xstep = r_sx < r_sy;
    assign w_nmx = w_xstep ? (r_rx[RAY_W-1] ? r_mx - M_W'(1) : r_mx + M_W'(1)) : r_mx;
    assign w_nmy = w_xstep ? r_my : (r_ry[RAY_W-1] ? r_my - M_W'(1) : r_my + M_W'(1));
    assign w_lin = LIN_W'(w_nmy) * LIN_W'(MAP_DIM) + LIN_W'(w_nmx);
    assign w_oob = (r_mx < 0) || (r_mx >= M_W'(MAP_DIM))
                || (r_my < 0) || (r_my >= M_W'(MAP_DIM));

    assign w_perp = r_side[0] ? r_sy - SUM_W'(r_dy) : r_sx - SUM_W'(r_dx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_col  <= w_in_col;
            r_camx <= $signed({1'b0, w_cam_prod[48:22]}) - CAM_W'(ONE_Q16);
        end
        if (i_cmd.ld_div) begin
            case (i_cmd.div_sel)
                DIV_DX:  r_dx <= w_quo[DELTA_W] ? '1 : w_quo[DELTA_W-1:0];
                DIV_DY:  r_dy <= w_quo[DELTA_W] ? '1 : w_quo[DELTA_W-1:0];
                DIV_LH:  r_lh <= (|w_quo[DIV_N_W-1:LH_W]) ? '1 : w_quo[LH_W-1:0];
                default: ;
            endcase
        end
        if (i_cmd.ray_mul) begin
            r_prod_x <= r_plane_x * r_camx;
            r_prod_y <= r_plane_y * r_camx;
        end
        if (i_cmd.ray_add) begin
            r_rx <= RAY_W'(r_dir_x) + RAY_W'(r_prod_x >>> 16);
            r_ry <= RAY_W'(r_dir_y) + RAY_W'(r_prod_y >>> 16);
        end
        if (i_cmd.side_mul) begin
            r_sx   <= SUM_W'(w_px[48:16]);
            r_sy   <= SUM_W'(w_py[48:16]);
            r_mx   <= M_W'(r_pos_x[21:16]);
            r_my   <= M_W'(r_pos_y[21:16]);
            r_n    <= '0;
            r_side <= SIDE_XNEG;
            r_hit  <= 1'b0;
            r_dist <= '1;
            r_lh   <= '0;
        end
        if (i_cmd.step) begin
            r_mx <= w_nmx;
            r_my <= w_nmy;
            r_n  <= r_n + 1'b1;
            if (w_xstep) begin
                r_sx   <= r_sx + SUM_W'(r_dx);
                r_side <= r_rx[RAY_W-1] ? SIDE_XNEG : SIDE_XPOS;
            end else begin
                r_sy   <= r_sy + SUM_W'(r_dy);
                r_side <= r_ry[RAY_W-1] ? SIDE_YNEG : SIDE_YPOS;
            end
        end
        if (i_cmd.calc_dist) begin
            r_hit <= 1'b1;
            if (w_perp == '0) begin
                r_dist <= DIST_W'(ONE_Q16);
            end else if (|w_perp[SUM_W-1:DIST_W]) begin
                r_dist <= '1;
            end else begin
                r_dist <= w_perp[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = 1'b0;
        if (i_cmd.clr_we) begin
            w_we = 1'b1;
        end else if (i_cmd.map_we) begin
            w_we    = (32'(w_in_cx) < MAP_DIM) && (32'(w_in_cy) < MAP_DIM);
            w_waddr = ADDR_W'(32'(w_in_cy) * MAP_DIM + 32'(w_in_cx));
            w_wdata = w_in_wall;
        end
    end

    gdr_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_lin[ADDR_W-1:0]),
        .o_rdata (w_rd)
    );

    assign w_half_lh = {2'b0, r_lh[LH_W-1:1]};
    assign w_ds = (w_half_lh > 17'(HALF)) ? '0 : DS_W'(17'(HALF) - w_half_lh);
    assign w_de_sum = 17'(HALF) + w_half_lh;
    assign w_de = (w_de_sum >= 17'(SCREEN_HEIGHT)) ? DE_W'(SCREEN_HEIGHT - 1)
                                                   : w_de_sum[DE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tdata <= {7'b0, w_de, w_ds, r_lh, r_dist,
                          r_hit ? r_my[CELL_W-1:0] : CELL_W'(0),
                          r_hit ? r_mx[CELL_W-1:0] : CELL_W'(0),
                          r_hit ? r_side : SIDE_XNEG,
                          r_col};
            r_m_tuser <= !r_hit;
        end
    end

    assign o_stat.clr_done = r_clr == ADDR_W'(DEPTH - 1);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.div_done = w_div_done;
    assign o_stat.wall     = w_oob || w_rd;
    assign o_stat.limit    = r_n == N_W'(MAX_STEPS);
    assign o_stat.out_free = !r_m_tvalid || i_m_tready;

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
endmodule

@@ rtl/gdr_ctrl.sv @@
`timescale 1ns / 1ps
module gdr_ctrl
    import gdr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_s_tuser,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_tready
);
    typedef enum logic [14:0] {
        S_CLEAR    = 15'h0001,
        S_IDLE     = 15'h0002,
        S_RAY_MUL  = 15'h0004,
        S_RAY_ADD  = 15'h0008,
        S_DX_GO    = 15'h0010,
        S_DX_WAIT  = 15'h0020,
        S_DY_GO    = 15'h0040,
        S_DY_WAIT  = 15'h0080,
        S_SIDE_MUL = 15'h0100,
        S_STEP     = 15'h0200,
        S_CHECK    = 15'h0400,
        S_DIST     = 15'h0800,
        S_LH_GO    = 15'h1000,
        S_LH_WAIT  = 15'h2000,
        S_FIN      = 15'h4000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_s_tuser == OP_CAST) begin
                        o_cmd.ld_in = 1'b1;
                        n_state     = S_RAY_MUL;
                    end else begin
                        o_cmd.map_we = 1'b1;
                    end
                end
            end
            S_RAY_MUL: begin
                o_cmd.ray_mul = 1'b1;
                n_state       = S_RAY_ADD;
            end
            S_RAY_ADD: begin
                o_cmd.ray_add = 1'b1;
                n_state       = S_DX_GO;
            end
            S_DX_GO: begin
                o_cmd.div_sel   = DIV_DX;
                o_cmd.div_start = 1'b1;
                n_state         = S_DX_WAIT;
            end
            S_DX_WAIT: begin
                o_cmd.div_sel = DIV_DX;
                o_cmd.ld_div  = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_DY_GO;
                end
            end
            S_DY_GO: begin
                o_cmd.div_sel   = DIV_DY;
                o_cmd.div_start = 1'b1;
                n_state         = S_DY_WAIT;
            end
            S_DY_WAIT: begin
                o_cmd.div_sel = DIV_DY;
                o_cmd.ld_div  = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_SIDE_MUL;
                end
            end
            S_SIDE_MUL: begin
                o_cmd.side_mul = 1'b1;
                n_state        = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.wall) begin
                    n_state = S_DIST;
                end else if (i_stat.limit) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIST: begin
                o_cmd.calc_dist = 1'b1;
                n_state         = S_LH_GO;
            end
            S_LH_GO: begin
                o_cmd.div_sel   = DIV_LH;
                o_cmd.div_start = 1'b1;
                n_state         = S_LH_WAIT;
            end
            S_LH_WAIT: begin
                o_cmd.div_sel = DIV_LH;
                o_cmd.ld_div  = i_stat.div_done;
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

@@ tb/sv/grid_dda_raycaster_tb.sv @@
`timescale 1ns / 1ps
module grid_dda_raycaster_tb;
    import gdr_pkg::*;

    localparam int SCR_W   = DEF_SCREEN_WIDTH;
    localparam int SCR_H   = DEF_SCREEN_HEIGHT;
    localparam int GRID    = DEF_MAP_DIM;
    localparam int STEPS   = DEF_MAX_STEPS;
    localparam int LIMIT   = 4000000;
    localparam int SETTLE  = 20;
    localparam longint unsigned DELTA_MAX = 64'hFFFF_FFFF;
    localparam longint unsigned DIST_MAX  = 64'hFF_FFFF;

    typedef struct {
        logic [COL_W-1:0]  column;
        logic [SIDE_W-1:0] side;
        logic [CELL_W-1:0] hit_x;
        logic [CELL_W-1:0] hit_y;
        logic [DIST_W-1:0] distance;
        logic [LH_W-1:0]   height;
        logic [DS_W-1:0]   row_start;
        logic [DE_W-1:0]   row_end;
        logic              no_hit;
    } cast_result_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    grid_dda_raycaster dut (.*);

    // predictor state
    logic [POS_W-1:0]        pos_x_m, pos_y_m;
    logic signed [VEC_W-1:0] dir_x_m, dir_y_m, plane_x_m, plane_y_m;
    bit                      wall_map [GRID*GRID];

    cast_result_t expected_casts[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_until;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (cycles < hold_until)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic cast_result_t predict_cast(logic [COL_W-1:0] col);
        cast_result_t r;
        longint camx, rx, ry, mx, my, lh, ds, de, ax, ay;
        longint unsigned dx, dy, sx, sy, fx, fy, perp, wall_dist;
        int side;
        bit hit;
        camx = longint'((64'd2 * col * ONE_Q16) / SCR_W) - ONE_Q16;
        rx = longint'(dir_x_m) + ((longint'(plane_x_m) * camx) >>> 16);
        ry = longint'(dir_y_m) + ((longint'(plane_y_m) * camx) >>> 16);
        mx = longint'(pos_x_m >> 16);
        my = longint'(pos_y_m >> 16);
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        dx = ax == 0 ? DELTA_MAX : (64'd1 << 32) / longint'(ax);
        dy = ay == 0 ? DELTA_MAX : (64'd1 << 32) / longint'(ay);
        if (dx > DELTA_MAX) dx = DELTA_MAX;
        if (dy > DELTA_MAX) dy = DELTA_MAX;
        fx = pos_x_m[15:0];
        fy = pos_y_m[15:0];
        if (rx >= 0) fx = ONE_Q16 - fx;
        if (ry >= 0) fy = ONE_Q16 - fy;
        sx = (fx * dx) >> 16;
        sy = (fy * dy) >> 16;
        side = SIDE_XNEG;
        hit = 1'b0;
        wall_dist = DIST_MAX;
        for (int n = 0; n < STEPS && !hit; n++) begin
            if (sx < sy) begin
                sx += dx;
                mx += rx < 0 ? -1 : 1;
                side = rx < 0 ? SIDE_XNEG : SIDE_XPOS;
            end else begin
                sy += dy;
                my += ry < 0 ? -1 : 1;
                side = ry < 0 ? SIDE_YNEG : SIDE_YPOS;
            end
            hit = (mx < 0 || my < 0 || mx >= GRID || my >= GRID) ? 1'b1
                : wall_map[my*GRID + mx];
        end
        if (hit) begin
            perp = (side == SIDE_XNEG || side == SIDE_XPOS) ? sx - dx : sy - dy;
            if (perp == 0) perp = ONE_Q16;
            wall_dist = perp > DIST_MAX ? DIST_MAX : perp;
            lh = longint'((64'(SCR_H) * ONE_Q16) / wall_dist);
            if (lh > 65535) lh = 65535;
        end else begin
            side = SIDE_XNEG;
            mx = 0;
            my = 0;
            lh = 0;
        end
        ds = SCR_H / 2 - lh / 2;
        if (ds < 0) ds = 0;
        de = SCR_H / 2 + lh / 2;
        if (de >= SCR_H) de = SCR_H - 1;
        r.column    = col;
        r.side      = side[SIDE_W-1:0];
        r.hit_x     = mx[CELL_W-1:0];
        r.hit_y     = my[CELL_W-1:0];
        r.distance  = wall_dist[DIST_W-1:0];
        r.height    = lh[LH_W-1:0];
        r.row_start = ds[DS_W-1:0];
        r.row_end   = de[DE_W-1:0];
        r.no_hit    = !hit;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            errors++;
            $display("%0t: %s mismatch expected %0d actual %0d", $time, name, e, a);
        end
    endfunction

    always @(posedge i_clk) begin
        cast_result_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_casts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result expected none actual %h", $time,
                         m_axis_tdata);
            end else begin
                e = expected_casts.pop_front();
                check_field("column", e.column, m_axis_tdata[9:0]);
                check_field("side", e.side, m_axis_tdata[11:10]);
                check_field("hit_x", e.hit_x, m_axis_tdata[17:12]);
                check_field("hit_y", e.hit_y, m_axis_tdata[23:18]);
                check_field("wall_distance", e.distance, m_axis_tdata[47:24]);
                check_field("line_height", e.height, m_axis_tdata[63:48]);
                check_field("start_row", e.row_start, m_axis_tdata[71:64]);
                check_field("end_row", e.row_end, m_axis_tdata[80:72]);
                check_field("no_hit", e.no_hit, m_axis_tuser);
            end
        end
    end

    // Drives one input transaction; valid stays high unless the sender idles.
    task automatic send_item(logic op, logic [COL_W-1:0] col, logic [CELL_W-1:0] cx,
                             logic [CELL_W-1:0] cy, logic wall);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, wall, cy, cx, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_CAST)
            expected_casts.push_back(predict_cast(col));
        else
            wall_map[cy*GRID + cx] = wall;
    endtask

    task automatic cast(logic [COL_W-1:0] col);
        send_item(OP_CAST, col, CELL_W'($urandom), CELL_W'($urandom), 1'($urandom));
    endtask

    task automatic put_cell(int x, int y, bit wall);
        send_item(OP_WRITE, COL_W'($urandom), CELL_W'(x), CELL_W'(y), wall);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_casts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_POS_X:   pos_x_m   = val;
            REG_POS_Y:   pos_y_m   = val;
            REG_DIR_X:   dir_x_m   = val[VEC_W-1:0];
            REG_DIR_Y:   dir_y_m   = val[VEC_W-1:0];
            REG_PLANE_X: plane_x_m = val[VEC_W-1:0];
            REG_PLANE_Y: plane_y_m = val[VEC_W-1:0];
            default: ;
        endcase
    endtask

    // Upper bits of the vector registers are random to exercise truncation.
    task automatic set_view(int px, int py, int dx, int dy, int plx, int ply);
        drain();
        cfg_write(REG_POS_X, CFG_W'(px));
        cfg_write(REG_POS_Y, CFG_W'(py));
        cfg_write(REG_DIR_X, {4'($urandom), VEC_W'(dx)});
        cfg_write(REG_DIR_Y, {4'($urandom), VEC_W'(dy)});
        cfg_write(REG_PLANE_X, {4'($urandom), VEC_W'(plx)});
        cfg_write(REG_PLANE_Y, {4'($urandom), VEC_W'(ply)});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_defaults();
        cast(0);
        cast(319);
        cast(639);
        cast(1023);
        cast(COL_W'($urandom_range(1023)));
    endtask

    task automatic test_map_edges();
        put_cell(0, 0, 1);
        put_cell(63, 63, 1);
        put_cell(3, 1, 1);
        put_cell(1, 3, 1);
        cast(320);
        cast(0);
        put_cell(3, 1, 0);
        put_cell(63, 63, 0);
        put_cell(0, 0, 0);
        cast(320);
        // start inside a wall: the starting cell is never tested
        put_cell(1, 1, 1);
        cast(100);
        put_cell(1, 1, 0);
    endtask

    task automatic test_extreme_views();
        // long diagonal from the corner, aimed at the step limit
        set_view(0, 0, 131071, 131071, 0, 0);
        cast(0);
        cast(639);
        set_view(4194303, 4194303, -131072, -131072, 131071, -131072);
        cast(0);
        cast(1023);
        cast(320);
        // zero ray components
        set_view(2097152, 2097152, 0, 0, 0, 0);
        cast(320);
        set_view(65536, 4194303, 0, -131072, -131072, 0);
        cast(320);
        cast(0);
    endtask

    task automatic random_items(int count);
        int x, y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 60) begin
                cast(COL_W'($urandom_range(99) < 90 ? $urandom_range(SCR_W-1)
                                                    : $urandom_range(1023)));
            end else begin
                x = $urandom_range(GRID-1);
                y = $urandom_range(GRID-1);
                put_cell(x, y, $urandom_range(99) < 35);
            end
        end
    endtask

    task automatic random_view();
        set_view($urandom_range(4194303), $urandom_range(4194303),
                 $urandom_range(262143), $urandom_range(262143),
                 $urandom_range(262143), $urandom_range(262143));
    endtask

    task automatic test_random_phase(int snd, int rcv, int count);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        random_view();
        random_items(count / 2);
        random_view();
        random_items(count - count / 2);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_view(2129920, 2129920, 65536, 0, 0, 43254);
        hold_until = cycles + 3000;
        for (int i = 0; i < 8; i++) cast(COL_W'($urandom_range(SCR_W-1)));
        drain();
    endtask

    initial begin
        hold_until    = 0;
        send_idle_pct = 27;
        recv_idle_pct = 53;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        m_axis_tready = 1'b0;
        pos_x_m   = 22'd98304;
        pos_y_m   = 22'd98304;
        dir_x_m   = 18'sd65536;
        dir_y_m   = '0;
        plane_x_m = '0;
        plane_y_m = 18'sd43254;
        foreach (wall_map[i]) wall_map[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_map_edges();
        test_extreme_views();
        test_backpressure();
        test_random_phase(27, 53, 260);
        test_random_phase(53, 27, 260);
        test_random_phase(0, 0, 260);

        drain();
        repeat (600) @(posedge i_clk);
        if (errors == 0 && expected_casts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0t: %0d results missing", $time, expected_casts.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
